// ===== src/ljpf_pkg.sv =====
package ljpf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DIST_W    = 31;
    localparam int DATA_W    = 32;
    localparam int SUM_W     = 48;
    localparam int Q_W       = 62;
    localparam int NUM_W     = Q_W + FRAC_BITS + 1;
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);
    localparam int DIG_W     = 16;
    localparam int NDIG      = (Q_W + DIG_W - 1) / DIG_W;
    localparam int MB_W      = NDIG * DIG_W;
    localparam int MP_W      = Q_W + MB_W;
    localparam int P64_W     = 64;
    localparam int MUL_CNT_W = $clog2(NDIG + 1);
    localparam int NLANE     = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [Q_W-1:0] QMAX       = {Q_W{1'b1}};
    localparam logic [Q_W-1:0] QMAX_DIV4  = QMAX >> 2;
    localparam logic [Q_W-1:0] QMAX_DIV24 = QMAX / 24;
    localparam logic [DIST_W-1:0] ONE_FIX = DIST_W'(1) << FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] CFG_EPSILON = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGMA   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SIG,
        ST_S2,
        ST_S4,
        ST_S6,
        ST_S12,
        ST_EN,
        ST_FS,
        ST_SCAL,
        ST_LANE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              start;
        logic              f_neg;
        logic [Q_W-1:0]    scalar;
        logic [DIST_W-1:0] sep;
    } lane_cmd_t;

    function automatic logic [DATA_W-1:0] sat32(input logic [Q_W-1:0] mag, input logic neg);
        logic [DATA_W-1:0] res;
        if (neg)
        begin
            if (mag >= Q_W'(64'h8000_0000))
                res = 32'h8000_0000;
            else
                res = DATA_W'(0) - mag[DATA_W-1:0];
        end
        else
        begin
            if (mag > Q_W'(64'h7FFF_FFFF))
                res = 32'h7FFF_FFFF;
            else
                res = mag[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== src/ljpf_mul.sv =====
module ljpf_mul
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [ljpf_pkg::Q_W-1:0] a,
    input  logic [ljpf_pkg::Q_W-1:0] b,
    output logic [ljpf_pkg::Q_W-1:0] result,
    output logic                 done
);
    import ljpf_pkg::*;

    logic [Q_W-1:0]       a_reg;
    logic [MB_W-1:0]      b_reg;
    logic [MP_W-1:0]      acc_reg;
    logic [MUL_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 fin_reg;
    logic                 done_reg;
    logic [Q_W-1:0]       result_reg;

    logic [DIG_W-1:0]       digit;
    logic [Q_W+DIG_W-1:0]   part;
    logic                   over;
    logic [P64_W-FRAC_BITS:0] rnd;

    assign digit = b_reg[MB_W-1 -: DIG_W];
    assign part  = a_reg * digit;
    assign over  = |acc_reg[MP_W-1:P64_W];
    assign rnd   = (P64_W-FRAC_BITS+1)'(acc_reg[P64_W-1:FRAC_BITS])
                 + (P64_W-FRAC_BITS+1)'(acc_reg[FRAC_BITS-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= MUL_CNT_W'(NDIG);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == MUL_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= MB_W'(b);
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= (acc_reg << DIG_W) + MP_W'(part);
            b_reg   <= b_reg << DIG_W;
        end
        if (fin_reg)
            result_reg <= over ? QMAX : Q_W'(rnd);
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

// ===== src/ljpf_div.sv =====
module ljpf_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ljpf_pkg::Q_W-1:0]    num,
    input  logic [ljpf_pkg::DIST_W-1:0] den,
    output logic [ljpf_pkg::Q_W-1:0]    result,
    output logic                        done
);
    import ljpf_pkg::*;

    logic [DIST_W-1:0]    den_reg;
    logic [DIST_W-1:0]    rem_reg;
    logic [NUM_W-1:0]     quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 fin_reg;
    logic                 done_reg;
    logic [Q_W-1:0]       result_reg;

    logic [DIST_W:0] rem2;
    logic [DIST_W:0] diff;
    logic            ge;

    assign rem2 = {rem_reg, quo_reg[NUM_W-1]};
    assign ge   = rem2 >= {1'b0, den_reg};
    assign diff = rem2 - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= (NUM_W'(num) << FRAC_BITS) + NUM_W'(den >> 1);
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DIST_W-1:0] : rem2[DIST_W-1:0];
            quo_reg <= {quo_reg[NUM_W-2:0], ge};
        end
        if (fin_reg)
            result_reg <= (|quo_reg[NUM_W-1:Q_W]) ? QMAX : quo_reg[Q_W-1:0];
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

// ===== src/ljpf_lane.sv =====
module ljpf_lane
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  ljpf_pkg::lane_cmd_t         cmd,
    input  logic [ljpf_pkg::DATA_W-1:0] disp,
    output logic [ljpf_pkg::DATA_W-1:0] force_out,
    output logic                        done
);
    import ljpf_pkg::*;

    logic [DIST_W-1:0] dist_reg;
    logic              neg_reg;
    logic [DATA_W-1:0] force_reg;
    logic              done_reg;

    logic [DATA_W:0]   dmag;
    logic [Q_W-1:0]    mul_res;
    logic              mul_done;
    logic [Q_W-1:0]    div_res;
    logic              div_done;

    assign dmag = disp[DATA_W-1] ? ((DATA_W+1)'(1) << DATA_W) - {1'b0, disp}
                                 : {1'b0, disp};

    ljpf_mul u_mul
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cmd.start),
        .a      (Q_W'(dmag)),
        .b      (cmd.scalar),
        .result (mul_res),
        .done   (mul_done)
    );

    ljpf_div u_div
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_done),
        .num    (mul_res),
        .den    (dist_reg),
        .result (div_res),
        .done   (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= div_done;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            dist_reg <= cmd.sep;
            neg_reg  <= disp[DATA_W-1] ^ cmd.f_neg;
        end
        if (div_done)
            force_reg <= sat32(div_res, neg_reg);
    end

    assign force_out = force_reg;
    assign done      = done_reg;

endmodule

// ===== src/lennard_jones_pair_force_core.sv =====
// Lennard-Jones 12-6 pair force core, Q16.16. One pair word is taken at a time while in_stall
// is low; the force vector, the pair energy and the running energy total come out as one word.
// The work is done by bit-serial dividers (sigma/r, the force scalar divide by r, then one more
// per force lane) and digit-serial multiplies (six in sequence, then one more per force lane);
// the three force components run in parallel lanes. A finished word waits in the output
// register while the next pair is taken. The energy total starts at zero after reset and
// saturates at the 48-bit range.
module lennard_jones_pair_force_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [ljpf_pkg::DIST_W-1:0]    distance,
    input  logic [ljpf_pkg::DATA_W-1:0]    disp_x,
    input  logic [ljpf_pkg::DATA_W-1:0]    disp_y,
    input  logic [ljpf_pkg::DATA_W-1:0]    disp_z,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ljpf_pkg::DATA_W-1:0]    force_x,
    output logic [ljpf_pkg::DATA_W-1:0]    force_y,
    output logic [ljpf_pkg::DATA_W-1:0]    force_z,
    output logic [ljpf_pkg::DATA_W-1:0]    pair_energy,
    output logic [ljpf_pkg::SUM_W-1:0]     energy_total,
    input  logic                           cfg_we,
    input  logic [ljpf_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ljpf_pkg::DIST_W-1:0]    cfg_data
);
    import ljpf_pkg::*;

    state_t state_reg, state_next;
    logic   go_reg, go_next;
    logic [NLANE-1:0] got_reg, got_next;
    logic   out_valid_reg, out_valid_next;

    logic [DIST_W-1:0] eps_reg;
    logic [DIST_W-1:0] sigma_reg;
    logic [SUM_W-1:0]  sum_reg;

    logic [DIST_W-1:0] r_reg;
    logic [DATA_W-1:0] disp_reg [NLANE];
    logic [Q_W-1:0]    s_reg, s2_reg, s4_reg, s6_reg;
    logic [Q_W-1:0]    de_reg, df_reg, m24_reg, scalar_reg;
    logic              e_neg_reg, f_neg_reg;
    logic [DATA_W-1:0] e_bits_reg;
    logic [DATA_W-1:0] fx_reg, fy_reg, fz_reg, pe_reg;

    logic [Q_W-1:0] mul_a, mul_b, mul_res, div_num, div_res;
    logic           mul_start, div_start, mul_done, div_done;
    lane_cmd_t      lane_cmd;
    logic [DATA_W-1:0] lane_force [NLANE];
    logic [NLANE-1:0]  lane_done;

    logic             accept, load_out;
    logic             e_neg;
    logic [Q_W:0]     two12, s6e, dfull;
    logic [Q_W-1:0]   de, m4;
    logic [Q_W+4:0]   m24w;
    logic [SUM_W-1:0] e_ext;
    logic [SUM_W:0]   sum_w;
    logic [SUM_W-1:0] sum_sat;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);

    ljpf_mul u_mul
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start),
        .a      (mul_a),
        .b      (mul_b),
        .result (mul_res),
        .done   (mul_done)
    );

    ljpf_div u_div
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (r_reg),
        .result (div_res),
        .done   (div_done)
    );

    assign lane_cmd.start  = go_reg && (state_reg == ST_LANE);
    assign lane_cmd.f_neg  = f_neg_reg;
    assign lane_cmd.scalar = scalar_reg;
    assign lane_cmd.sep    = r_reg;

    genvar gi;
    generate
        for (gi = 0; gi < NLANE; gi++)
        begin : g_lane
            ljpf_lane u_lane
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (lane_cmd),
                .disp      (disp_reg[gi]),
                .force_out (lane_force[gi]),
                .done      (lane_done[gi])
            );
        end
    endgenerate

    // energy and force differences from s12 (mul result) and s6
    assign e_neg = mul_res < s6_reg;
    assign de    = e_neg ? (s6_reg - mul_res) : (mul_res - s6_reg);
    assign two12 = {mul_res, 1'b0};
    assign s6e   = {1'b0, s6_reg};
    assign dfull = (two12 > s6e) ? (two12 - s6e) : (s6e - two12);
    assign m4    = (mul_res > QMAX_DIV4) ? QMAX : (mul_res << 2);
    assign m24w  = ((Q_W+5)'(mul_res) << 4) + ((Q_W+5)'(mul_res) << 3);

    assign e_ext   = {{(SUM_W-DATA_W){e_bits_reg[DATA_W-1]}}, e_bits_reg};
    assign sum_w   = {sum_reg[SUM_W-1], sum_reg} + {e_ext[SUM_W-1], e_ext};
    assign sum_sat = (sum_w[SUM_W] != sum_w[SUM_W-1])
                   ? (sum_w[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}})
                   : sum_w[SUM_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        go_next        = 1'b0;
        got_next       = got_reg;
        out_valid_next = out_valid_reg;
        load_out       = 1'b0;
        mul_a          = s_reg;
        mul_b          = s_reg;
        div_num        = Q_W'(sigma_reg);
        mul_start      = 1'b0;
        div_start      = 1'b0;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SIG;
                    go_next    = 1'b1;
                end
            end
            ST_SIG:
            begin
                div_start = go_reg;
                if (div_done)
                begin
                    state_next = ST_S2;
                    go_next    = 1'b1;
                end
            end
            ST_S2:
            begin
                mul_start = go_reg;
                if (mul_done)
                begin
                    state_next = ST_S4;
                    go_next    = 1'b1;
                end
            end
            ST_S4:
            begin
                mul_a     = s2_reg;
                mul_b     = s2_reg;
                mul_start = go_reg;
                if (mul_done)
                begin
                    state_next = ST_S6;
                    go_next    = 1'b1;
                end
            end
            ST_S6:
            begin
                mul_a     = s4_reg;
                mul_b     = s2_reg;
                mul_start = go_reg;
                if (mul_done)
                begin
                    state_next = ST_S12;
                    go_next    = 1'b1;
                end
            end
            ST_S12:
            begin
                mul_a     = s6_reg;
                mul_b     = s6_reg;
                mul_start = go_reg;
                if (mul_done)
                begin
                    state_next = ST_EN;
                    go_next    = 1'b1;
                end
            end
            ST_EN:
            begin
                mul_a     = Q_W'(eps_reg);
                mul_b     = de_reg;
                mul_start = go_reg;
                if (mul_done)
                begin
                    state_next = ST_FS;
                    go_next    = 1'b1;
                end
            end
            ST_FS:
            begin
                mul_a     = Q_W'(eps_reg);
                mul_b     = df_reg;
                mul_start = go_reg;
                if (mul_done)
                begin
                    state_next = ST_SCAL;
                    go_next    = 1'b1;
                end
            end
            ST_SCAL:
            begin
                div_num   = m24_reg;
                div_start = go_reg;
                if (div_done)
                begin
                    state_next = ST_LANE;
                    go_next    = 1'b1;
                    got_next   = '0;
                end
            end
            ST_LANE:
            begin
                got_next = got_reg | lane_done;
                if ((got_reg | lane_done) == {NLANE{1'b1}})
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            go_reg        <= 1'b0;
            got_reg       <= '0;
            out_valid_reg <= 1'b0;
            eps_reg       <= ONE_FIX;
            sigma_reg     <= ONE_FIX;
            sum_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            go_reg        <= go_next;
            got_reg       <= got_next;
            out_valid_reg <= out_valid_next;
            if (load_out)
                sum_reg <= sum_sat;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_EPSILON: eps_reg   <= cfg_data;
                    CFG_SIGMA:   sigma_reg <= cfg_data;
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            r_reg       <= (distance == '0) ? DIST_W'(1) : distance;
            disp_reg[0] <= disp_x;
            disp_reg[1] <= disp_y;
            disp_reg[2] <= disp_z;
        end
        if (state_reg == ST_SIG && div_done)
            s_reg <= div_res;
        if (state_reg == ST_S2 && mul_done)
            s2_reg <= mul_res;
        if (state_reg == ST_S4 && mul_done)
            s4_reg <= mul_res;
        if (state_reg == ST_S6 && mul_done)
            s6_reg <= mul_res;
        if (state_reg == ST_S12 && mul_done)
        begin
            e_neg_reg <= e_neg;
            de_reg    <= de;
            f_neg_reg <= two12 > s6e;
            df_reg    <= dfull[Q_W] ? QMAX : dfull[Q_W-1:0];
        end
        if (state_reg == ST_EN && mul_done)
            e_bits_reg <= sat32(m4, e_neg_reg);
        if (state_reg == ST_FS && mul_done)
            m24_reg <= (mul_res > QMAX_DIV24) ? QMAX : m24w[Q_W-1:0];
        if (state_reg == ST_SCAL && div_done)
            scalar_reg <= div_res;
        if (load_out)
        begin
            fx_reg <= lane_force[0];
            fy_reg <= lane_force[1];
            fz_reg <= lane_force[2];
            pe_reg <= e_bits_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign force_x      = fx_reg;
    assign force_y      = fy_reg;
    assign force_z      = fz_reg;
    assign pair_energy  = pe_reg;
    assign energy_total = sum_reg;

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;

    import ljpf_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] fx;
        logic [DATA_W-1:0] fy;
        logic [DATA_W-1:0] fz;
        logic [DATA_W-1:0] pe;
        logic [SUM_W-1:0]  total;
    } lj_word_t;

    typedef struct packed {
        logic [DIST_W-1:0] sep;
        logic [DATA_W-1:0] dx;
        logic [DATA_W-1:0] dy;
        logic [DATA_W-1:0] dz;
        bit                typed;
        lj_word_t          want;
    } pair_row_t;

    localparam logic [63:0] CAP_Q = (64'd1 << 62) - 64'd1;
    localparam longint TOTAL_MAX = 64'sd140737488355327;
    localparam longint TOTAL_MIN = -64'sd140737488355328;
    localparam int RAND_PER_PHASE = 270;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [DIST_W-1:0] distance = '0;
    logic [DATA_W-1:0] disp_x = '0;
    logic [DATA_W-1:0] disp_y = '0;
    logic [DATA_W-1:0] disp_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [DATA_W-1:0] force_x;
    logic [DATA_W-1:0] force_y;
    logic [DATA_W-1:0] force_z;
    logic [DATA_W-1:0] pair_energy;
    logic [SUM_W-1:0] energy_total;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_EPSILON;
    logic [DIST_W-1:0] cfg_data = '0;

    logic [DIST_W-1:0] eps_reg;
    logic [DIST_W-1:0] sig_reg;
    logic signed [SUM_W-1:0] energy_acc;
    lj_word_t force_q[$];
    int mismatches = 0;
    bit stall_hold = 1'b0;

    lennard_jones_pair_force_core dut (.*);

    always #2 clk = ~clk;

    function automatic logic [63:0] fix_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        logic [63:0] v;
        p = a * b;
        if (p[127:64] != 0)
            return CAP_Q;
        v = p[63:0];
        v = (v >> FRAC_BITS) + ((v >> (FRAC_BITS - 1)) & 64'd1);
        return v > CAP_Q ? CAP_Q : v;
    endfunction

    function automatic logic [63:0] fix_div(input logic [63:0] a, input logic [63:0] r);
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] frac;
        logic [63:0] v;
        q = a / r;
        rem = a % r;
        frac = ((rem << FRAC_BITS) + (r >> 1)) / r;
        if (q > (CAP_Q >> FRAC_BITS))
            return CAP_Q;
        v = (q << FRAC_BITS) + frac;
        return v > CAP_Q ? CAP_Q : v;
    endfunction

    function automatic logic [DATA_W-1:0] clamp_word(input logic [63:0] mag, input bit neg);
        if (neg)
            return mag >= 64'h8000_0000 ? 32'h8000_0000 : 32'(64'd0 - mag);
        return mag > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    function automatic lj_word_t predict_pair(input logic [DIST_W-1:0] sep,
                                              input logic [DATA_W-1:0] dx,
                                              input logic [DATA_W-1:0] dy,
                                              input logic [DATA_W-1:0] dz);
        lj_word_t w;
        logic [63:0] r, s, s2, s6, s12, d, m, scalar, two12, dmag, fmag;
        logic [DATA_W-1:0] comp[3];
        logic [DATA_W-1:0] fo[3];
        bit e_neg, f_neg, dneg;
        longint acc;
        r = (sep == 0) ? 64'd1 : 64'(sep);
        s = fix_div(64'(sig_reg), r);
        s2 = fix_mul(s, s);
        s6 = fix_mul(fix_mul(s2, s2), s2);
        s12 = fix_mul(s6, s6);
        e_neg = s12 < s6;
        d = e_neg ? s6 - s12 : s12 - s6;
        m = fix_mul(64'(eps_reg), d);
        m = m > (CAP_Q >> 2) ? CAP_Q : (m << 2);
        w.pe = clamp_word(m, e_neg);
        two12 = s12 << 1;
        f_neg = two12 > s6;
        d = f_neg ? two12 - s6 : s6 - two12;
        d = d > CAP_Q ? CAP_Q : d;
        m = fix_mul(64'(eps_reg), d);
        m = m > (CAP_Q / 24) ? CAP_Q : m * 24;
        scalar = fix_div(m, r);
        comp[0] = dx;
        comp[1] = dy;
        comp[2] = dz;
        for (int k = 0; k < 3; k++)
        begin
            dneg = comp[k][31];
            dmag = dneg ? (64'd1 << 32) - 64'(comp[k]) : 64'(comp[k]);
            fmag = fix_div(fix_mul(dmag, scalar), r);
            fo[k] = clamp_word(fmag, dneg != f_neg);
        end
        w.fx = fo[0];
        w.fy = fo[1];
        w.fz = fo[2];
        acc = longint'(energy_acc) + longint'($signed(w.pe));
        if (acc > TOTAL_MAX)
            acc = TOTAL_MAX;
        if (acc < TOTAL_MIN)
            acc = TOTAL_MIN;
        energy_acc = acc[SUM_W-1:0];
        w.total = acc[SUM_W-1:0];
        return w;
    endfunction

    // receiver stall pattern: phases of varying stall density, some with none
    always @(negedge clk)
    begin
        if (stall_hold)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < (($time / 20000) % 4) * 25);
    end

    always @(posedge clk)
    begin
        lj_word_t e;
        lj_word_t got;
        if (out_valid && !out_stall)
        begin
            got = '{force_x, force_y, force_z, pair_energy, energy_total};
            if (force_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: %h", got);
            end
            else
            begin
                e = force_q.pop_front();
                if (got != e)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch fx %h/%h fy %h/%h fz %h/%h pe %h/%h tot %h/%h",
                                 e.fx, got.fx, e.fy, got.fy, e.fz, got.fz,
                                 e.pe, got.pe, e.total, got.total);
                end
            end
        end
    end

    task automatic send_pair(input pair_row_t row);
        lj_word_t w;
        @(negedge clk);
        in_valid <= 1'b1;
        distance <= row.sep;
        disp_x <= row.dx;
        disp_y <= row.dy;
        disp_z <= row.dz;
        do
            @(posedge clk);
        while (in_stall);
        w = predict_pair(row.sep, row.dx, row.dy, row.dz);
        force_q.push_back(row.typed ? row.want : w);
    endtask

    task automatic drop_valid(input int gap);
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
    endtask

    task automatic drain_results();
        while (force_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_lj_regs(input logic [DIST_W-1:0] eps, input logic [DIST_W-1:0] sig);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_EPSILON;
        cfg_data <= eps;
        @(negedge clk);
        cfg_index <= CFG_SIGMA;
        cfg_data <= sig;
        @(negedge clk);
        cfg_we <= 1'b0;
        eps_reg = eps;
        sig_reg = sig;
    endtask

    function automatic pair_row_t random_pair();
        pair_row_t row;
        logic [63:0] base;
        row = '0;
        base = (sig_reg == 0) ? 64'h10000 : 64'(sig_reg);
        case ($urandom_range(0, 9))
            0, 1: row.sep = $urandom();
            2: row.sep = $urandom_range(0, 255);
            default: row.sep = 31'((base / 2) + (base * $urandom_range(0, 300)) / 100);
        endcase
        if ($urandom_range(0, 2) == 0)
        begin
            row.dx = $urandom();
            row.dy = $urandom();
            row.dz = $urandom();
        end
        else
        begin
            row.dx = 32'($signed(20'($urandom())));
            row.dy = 32'($signed(20'($urandom())));
            row.dz = 32'($signed(20'($urandom())));
        end
        return row;
    endfunction

    initial
    begin
        #40000000;
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        pair_row_t directed[$];
        pair_row_t row;
        logic [DIST_W-1:0] eps_set[6];
        logic [DIST_W-1:0] sig_set[6];
        int left;

        eps_reg = 31'h10000;
        sig_reg = 31'h10000;
        energy_acc = '0;

        row = '0;
        row.sep = 31'h10000;
        row.dx = 32'h0001_0000;
        row.dy = 32'h0;
        row.dz = 32'hFFFF_0000;
        row.typed = 1'b1;
        row.want = '{32'hFFE8_0000, 32'h0, 32'h0018_0000, 32'h0, 48'h0};
        directed.push_back(row);
        row = '0;
        row.sep = 31'h0;
        row.dx = 32'h7FFF_FFFF;
        row.dy = 32'h8000_0000;
        row.dz = 32'h1;
        directed.push_back(row);
        row.sep = 31'h7FFF_FFFF;
        row.dx = 32'h8000_0000;
        row.dy = 32'h7FFF_FFFF;
        row.dz = 32'hFFFF_FFFF;
        directed.push_back(row);
        row.sep = 31'h1_2000;
        row.dx = 32'h0000_8000;
        row.dy = 32'hFFFF_8000;
        row.dz = 32'h0;
        directed.push_back(row);
        row.sep = 31'h2_0000;
        row.dx = 32'h7FFF_FFFF;
        row.dy = 32'h8000_0000;
        row.dz = 32'h0001_0000;
        directed.push_back(row);
        row.sep = 31'h0_C000;
        row.dx = 32'h0002_0000;
        row.dy = 32'h0;
        row.dz = 32'hFFFE_0000;
        directed.push_back(row);
        row.sep = 31'h1;
        row.dx = 32'h0;
        row.dy = 32'h0;
        row.dz = 32'h0;
        directed.push_back(row);
        row.sep = 31'h3_0000;
        row.dx = 32'h5555_5555;
        row.dy = 32'hAAAA_AAAA;
        row.dz = 32'h0000_FFFF;
        directed.push_back(row);

        eps_set = '{31'h7FFF_FFFF, 31'h1, 31'h0, 31'h8000, 31'h0003_8000, 31'h10000};
        sig_set = '{31'h7FFF_FFFF, 31'h1, 31'h10000, 31'h0, 31'h0002_4000, 31'h0001_8000};

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(negedge clk);

        foreach (directed[i])
            send_pair(directed[i]);
        drop_valid(0);
        drain_results();

        for (int ph = 0; ph < 6; ph++)
        begin
            write_lj_regs(eps_set[ph], sig_set[ph]);
            left = RAND_PER_PHASE;
            while (left > 0)
            begin
                for (int b = $urandom_range(1, 12); b > 0 && left > 0; b--)
                begin
                    send_pair(random_pair());
                    left--;
                end
                if (ph == 2 && left < RAND_PER_PHASE / 2 && !stall_hold)
                begin
                    drop_valid(0);
                    stall_hold = 1'b1;
                    drain_results();
                end
                else if ($urandom_range(0, 3) != 0)
                    drop_valid($urandom_range(0, 40));
            end
            drop_valid(0);
            drain_results();
        end

        repeat (400) @(posedge clk);
        if (mismatches == 0 && force_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
